// ===== sv/cbts_pkg.sv =====
package cbts_pkg;

    // field widths
    localparam int RATE_W = 20;
    localparam int CLK_W  = 32;
    localparam int BRP_W  = 11;
    localparam int SEG1_W = 9;
    localparam int SEG2_W = 8;
    localparam int SJW_W  = 8;
    localparam int ERR_W  = 32;
    localparam int SP_W   = 10;
    localparam int PROD_W = BRP_W + RATE_W;

    // quanta per bit stay within 8..25, so five bits hold them
    localparam int TQ_W = 5;
    // 1000 / quanta is at most 125
    localparam int Q_W  = 7;

    localparam int unsigned SP_TARGET = 875;
    localparam int unsigned TQ_LOW    = 8;
    localparam int unsigned TQ_HIGH   = 25;
    localparam int unsigned PERMILLE  = 1000;

    typedef enum logic [2:0] {
        REG_CLOCK_HZ,
        REG_PRESCALER_MIN,
        REG_PRESCALER_MAX,
        REG_SEG1_MIN,
        REG_SEG1_MAX,
        REG_SEG2_MIN,
        REG_SEG2_MAX,
        REG_JUMP_WIDTH_MAX
    } cbts_reg_t;

    typedef struct packed {
        logic [CLK_W-1:0]  clock_hz;
        logic [BRP_W-1:0]  prescaler_min;
        logic [BRP_W-1:0]  prescaler_max;
        logic [SEG1_W-1:0] seg1_min;
        logic [SEG1_W-1:0] seg1_max;
        logic [SEG2_W-1:0] seg2_min;
        logic [SEG2_W-1:0] seg2_max;
        logic [SJW_W-1:0]  jump_width_max;
    } cbts_cfg_t;

    localparam cbts_cfg_t CFG_RESET = '{
        clock_hz:       32'd48000000,
        prescaler_min:  11'd1,
        prescaler_max:  11'd1024,
        seg1_min:       9'd1,
        seg1_max:       9'd16,
        seg2_min:       8'd1,
        seg2_max:       8'd8,
        jump_width_max: 8'd4
    };

    // best candidate of one search
    typedef struct packed {
        logic             found;
        logic [BRP_W-1:0] prescaler;
        logic [TQ_W-1:0]  phase_one;
        logic [TQ_W-1:0]  phase_two;
        logic [ERR_W-1:0] rate_error;
        logic [SP_W-1:0]  sp_permille;
    } cbts_result_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } cbts_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BRP,
        ST_MUL_D,
        ST_DIV_TQ,
        ST_MUL_BT,
        ST_DIV_ACT,
        ST_DIV_SP,
        ST_SCAN,
        ST_DONE
    } cbts_state_t;

endpackage

// ===== sv/can_bit_timing_search.sv =====
// CAN bit timing search. Each item on the input stream is a requested bitrate; the block
// walks the prescalers from prescaler_min to prescaler_max in steps of BRP_STEP, and for
// each one with 8 to 25 quanta per bit it scans phase segment one, keeping the candidate
// with the least bitrate error and then the sample point nearest 87.5%. One result item
// follows each request. All arithmetic goes through a bit-serial multiplier and a
// bit-serial 32-bit divider. A zero prescaler is skipped, and so is one with more than 25
// quanta once they are divided out; one inside the range also gets a bitrate and a sample
// point division and a scan of phase one; the walk ends early at the first prescaler with
// fewer than 8 quanta. A new request is taken once the previous search has handed its
// result to the output register. Configuration registers are written through cfg_* and
// are read by the search throughout, so the user must write them only while no request is
// in flight; the block itself does not enforce it.
module can_bit_timing_search
    import cbts_pkg::*;
#(
    parameter int BRP_STEP = 1
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // [19:0] target_rate
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,  // prescaler, phase_one, phase_two, jump_width,
                                  // rate_error, sp_permille
    output logic [0:0]  m_tuser   // status
);

    cbts_cfg_t    cfg_reg;
    cbts_status_t status;
    cbts_result_t result;
    logic         res_ready;
    logic         m_tvalid_reg;
    logic [79:0]  m_tdata_reg;
    logic [79:0]  m_tdata_next;
    logic [0:0]   m_tuser_reg;
    logic [SJW_W-1:0] s2_wide;
    logic [SJW_W-1:0] sjw;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid) begin
            case (cbts_reg_t'(cfg_index))
                REG_CLOCK_HZ:       cfg_reg.clock_hz       <= cfg_data;
                REG_PRESCALER_MIN:  cfg_reg.prescaler_min  <= cfg_data[BRP_W-1:0];
                REG_PRESCALER_MAX:  cfg_reg.prescaler_max  <= cfg_data[BRP_W-1:0];
                REG_SEG1_MIN:       cfg_reg.seg1_min       <= cfg_data[SEG1_W-1:0];
                REG_SEG1_MAX:       cfg_reg.seg1_max       <= cfg_data[SEG1_W-1:0];
                REG_SEG2_MIN:       cfg_reg.seg2_min       <= cfg_data[SEG2_W-1:0];
                REG_SEG2_MAX:       cfg_reg.seg2_max       <= cfg_data[SEG2_W-1:0];
                REG_JUMP_WIDTH_MAX: cfg_reg.jump_width_max <= cfg_data[SJW_W-1:0];
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    cbts_search #(
        .BRP_STEP (BRP_STEP)
    ) u_search (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_tvalid & s_tready),
        .rate      (s_tdata[RATE_W-1:0]),
        .cfg       (cfg_reg),
        .res_ready (res_ready),
        .status    (status),
        .result    (result)
    );

    assign s_tready = status.idle;

    // result packing, zeros when no timing exists
    assign s2_wide = SJW_W'(result.phase_two);
    assign sjw     = (s2_wide < cfg_reg.jump_width_max) ? s2_wide : cfg_reg.jump_width_max;

    always_comb begin
        m_tdata_next = '0;
        if (result.found) begin
            m_tdata_next = {2'b00, result.sp_permille, result.rate_error, sjw,
                            SEG2_W'(result.phase_two), SEG1_W'(result.phase_one),
                            result.prescaler};
        end
    end

    // output register, loads when empty or being drained
    assign res_ready = status.res_valid && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= ~result.found;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== sv/cbts_mul.sv =====
module cbts_mul
    import cbts_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [BRP_W-1:0]  a,
    input  logic [RATE_W-1:0] b,
    output logic              done,
    output logic [PROD_W-1:0] product
);

    localparam int CntW = $clog2(BRP_W + 1);

    logic [CntW-1:0]   cnt_reg;
    logic              done_reg;
    logic [BRP_W-1:0]  a_reg;
    logic [PROD_W-1:0] b_reg;
    logic [PROD_W-1:0] acc_reg;

    // step counter, one multiplier bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == CntW'(1));
            if (start) begin
                cnt_reg <= CntW'(BRP_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CntW'(1);
            end
        end
    end

    // shift-add datapath, lsb of a first
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= PROD_W'(b);
            acc_reg <= '0;
        end else if (cnt_reg != '0) begin
            if (a_reg[0]) begin
                acc_reg <= acc_reg + b_reg;
            end
            a_reg <= a_reg >> 1;
            b_reg <= b_reg << 1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== sv/cbts_div.sv =====
module cbts_div
    import cbts_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [CLK_W-1:0] dividend,
    input  logic [CLK_W-1:0] divisor,
    output logic             done,
    output logic [CLK_W-1:0] quotient,
    output logic [CLK_W-1:0] remainder
);

    localparam int CntW = $clog2(CLK_W + 1);

    logic [CntW-1:0]  cnt_reg;
    logic             done_reg;
    logic [CLK_W-1:0] rem_reg;
    logic [CLK_W-1:0] quo_reg;
    logic [CLK_W-1:0] dvs_reg;
    logic [CLK_W:0]   trial;
    logic             fits;

    // restoring step: bring down the next dividend bit and try a subtract
    assign trial = {rem_reg, quo_reg[CLK_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    // step counter, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == CntW'(1));
            if (start) begin
                cnt_reg <= CntW'(CLK_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CntW'(1);
            end
        end
    end

    // dividend shifts out msb first while quotient bits shift in
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (cnt_reg != '0) begin
            rem_reg <= fits ? CLK_W'(trial - {1'b0, dvs_reg}) : trial[CLK_W-1:0];
            quo_reg <= {quo_reg[CLK_W-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== sv/cbts_search.sv =====
module cbts_search
    import cbts_pkg::*;
#(
    parameter int BRP_STEP = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [RATE_W-1:0] rate,
    input  cbts_cfg_t         cfg,
    input  logic              res_ready,
    output cbts_status_t      status,
    output cbts_result_t      result
);

    // prescaler counter must hold the largest prescaler plus one step
    localparam int BrpCntW = $clog2((1 << BRP_W) + BRP_STEP + 1);

    cbts_state_t state_reg, state_next;

    logic [BrpCntW-1:0] brp_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic [TQ_W-1:0]    tq_reg;
    logic [ERR_W-1:0]   err_reg;
    logic [Q_W-1:0]     spq_reg;
    logic [TQ_W-1:0]    spr_reg;
    logic [SP_W-1:0]    q_reg;
    logic [TQ_W-1:0]    r_reg;
    logic [TQ_W-1:0]    s1_reg;
    logic               found_reg;
    logic [ERR_W-1:0]   best_err_reg;
    logic [SP_W-1:0]    best_sperr_reg;
    logic [SP_W-1:0]    best_sp_reg;
    logic [BRP_W-1:0]   best_brp_reg;
    logic [TQ_W-1:0]    best_s1_reg;
    logic [TQ_W-1:0]    best_s2_reg;

    logic               mul_start;
    logic [RATE_W-1:0]  mul_b;
    logic               mul_done;
    logic [PROD_W-1:0]  mul_prod;
    logic               div_start;
    logic [CLK_W-1:0]   div_dividend;
    logic [CLK_W-1:0]   div_divisor;
    logic               div_done;
    logic [CLK_W-1:0]   div_quo;
    logic [CLK_W-1:0]   div_rem;

    logic               brp_over;
    logic               brp_zero;
    logic               tq_low;
    logic               tq_high;
    logic               brp_inc;
    logic               scan_last;
    logic [TQ_W-1:0]    s2;
    logic               cand;
    logic [SP_W-1:0]    sp_err;
    logic               better;
    logic [ERR_W-1:0]   err_new;
    logic [TQ_W:0]      r_sum;
    logic               r_wrap;
    logic [TQ_W-1:0]    r_step;
    logic [SP_W-1:0]    q_step;

    cbts_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (brp_reg[BRP_W-1:0]),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    cbts_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // loop and range tests
    assign brp_over  = brp_reg > BrpCntW'(cfg.prescaler_max);
    assign brp_zero  = (brp_reg == '0);
    assign tq_low    = div_quo < CLK_W'(TQ_LOW);
    assign tq_high   = div_quo > CLK_W'(TQ_HIGH);
    assign scan_last = (s1_reg == tq_reg - TQ_W'(1));
    assign brp_inc   = ((state_reg == ST_BRP) && !brp_over && brp_zero) ||
                       ((state_reg == ST_DIV_TQ) && div_done && !tq_low && tq_high) ||
                       ((state_reg == ST_SCAN) && scan_last);

    // bitrate error of the current prescaler
    assign err_new = (div_quo > CLK_W'(rate_reg)) ? div_quo - CLK_W'(rate_reg)
                                                  : CLK_W'(rate_reg) - div_quo;

    // candidate for the current phase one
    assign s2   = tq_reg - TQ_W'(1) - s1_reg;
    assign cand = (SEG1_W'(s1_reg) >= cfg.seg1_min) && (SEG1_W'(s1_reg) <= cfg.seg1_max) &&
                  (SEG2_W'(s2) >= cfg.seg2_min) && (SEG2_W'(s2) <= cfg.seg2_max);
    assign sp_err = (q_reg >= SP_W'(SP_TARGET)) ? q_reg - SP_W'(SP_TARGET)
                                                : SP_W'(SP_TARGET) - q_reg;
    assign better = !found_reg || (err_reg < best_err_reg) ||
                    ((err_reg == best_err_reg) && (sp_err < best_sperr_reg));

    // sample point of the next phase one: add 1000 / quanta with carry of remainders
    assign r_sum  = {1'b0, r_reg} + {1'b0, spr_reg};
    assign r_wrap = r_sum >= {1'b0, tq_reg};
    assign r_step = r_wrap ? TQ_W'(r_sum - {1'b0, tq_reg}) : r_sum[TQ_W-1:0];
    assign q_step = q_reg + SP_W'(spq_reg) + SP_W'(r_wrap);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = (rate == '0) ? ST_DONE : ST_BRP;
                end
            end
            ST_BRP: begin
                if (brp_over) begin
                    state_next = ST_DONE;
                end else if (!brp_zero) begin
                    state_next = ST_MUL_D;
                end
            end
            ST_MUL_D: begin
                if (mul_done) begin
                    state_next = ST_DIV_TQ;
                end
            end
            ST_DIV_TQ: begin
                if (div_done) begin
                    if (tq_low) begin
                        // quanta only shrink as the prescaler grows
                        state_next = ST_DONE;
                    end else if (tq_high) begin
                        state_next = ST_BRP;
                    end else begin
                        state_next = ST_MUL_BT;
                    end
                end
            end
            ST_MUL_BT: begin
                if (mul_done) begin
                    state_next = ST_DIV_ACT;
                end
            end
            ST_DIV_ACT: begin
                if (div_done) begin
                    state_next = ST_DIV_SP;
                end
            end
            ST_DIV_SP: begin
                if (div_done) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_BRP;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // unit starts and operand selection
    always_comb begin
        mul_start    = 1'b0;
        div_start    = 1'b0;
        mul_b        = rate_reg;
        div_dividend = cfg.clock_hz;
        div_divisor  = CLK_W'(mul_prod);
        status.idle      = 1'b0;
        status.res_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                status.idle = 1'b1;
            end
            ST_BRP: begin
                mul_start = !brp_over && !brp_zero;
            end
            ST_MUL_D: begin
                div_start = mul_done;
            end
            ST_DIV_TQ: begin
                mul_b     = RATE_W'(div_quo[TQ_W-1:0]);
                mul_start = div_done && !tq_low && !tq_high;
            end
            ST_MUL_BT: begin
                div_start = mul_done;
            end
            ST_DIV_ACT: begin
                div_dividend = CLK_W'(PERMILLE);
                div_divisor  = CLK_W'(tq_reg);
                div_start    = div_done;
            end
            ST_DONE: begin
                status.res_valid = 1'b1;
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // found flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if ((state_reg == ST_IDLE) && start) begin
            found_reg <= 1'b0;
        end else if ((state_reg == ST_SCAN) && cand) begin
            found_reg <= 1'b1;
        end
    end

    // search datapath
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_IDLE) && start) begin
            rate_reg <= rate;
            brp_reg  <= BrpCntW'(cfg.prescaler_min);
        end else if (brp_inc) begin
            brp_reg <= brp_reg + BrpCntW'(BRP_STEP);
        end
        if ((state_reg == ST_DIV_TQ) && div_done) begin
            tq_reg <= div_quo[TQ_W-1:0];
        end
        if ((state_reg == ST_DIV_ACT) && div_done) begin
            err_reg <= err_new;
        end
        if ((state_reg == ST_DIV_SP) && div_done) begin
            spq_reg <= div_quo[Q_W-1:0];
            spr_reg <= div_rem[TQ_W-1:0];
            q_reg   <= SP_W'(div_quo[Q_W-1:0]);
            r_reg   <= div_rem[TQ_W-1:0];
            s1_reg  <= '0;
        end else if (state_reg == ST_SCAN) begin
            q_reg  <= q_step;
            r_reg  <= r_step;
            s1_reg <= s1_reg + TQ_W'(1);
        end
        if ((state_reg == ST_SCAN) && cand && better) begin
            best_err_reg   <= err_reg;
            best_sperr_reg <= sp_err;
            best_sp_reg    <= q_reg;
            best_brp_reg   <= brp_reg[BRP_W-1:0];
            best_s1_reg    <= s1_reg;
            best_s2_reg    <= s2;
        end
    end

    assign result.found       = found_reg;
    assign result.prescaler   = best_brp_reg;
    assign result.phase_one   = best_s1_reg;
    assign result.phase_two   = best_s2_reg;
    assign result.rate_error  = best_err_reg;
    assign result.sp_permille = best_sp_reg;

endmodule
